FILE: hdl/b64lw_pkg.sv
// Package: shared types, constants and the Base64 alphabet for the line-wrapping encoder.
`timescale 1ns / 1ps
`default_nettype none
package b64lw_pkg;

  localparam int LINE_WIDTH_DEFAULT = 76;
  localparam int JOB_FIFO_DEPTH     = 4;
  localparam int COL_W              = 7;
  localparam int CFG_INDEX_W        = 2;
  localparam int CFG_DATA_W         = 8;

  localparam logic [1:0] SEP_LENGTH_RESET = 2'd2;
  localparam logic [7:0] SEP_FIRST_RESET  = 8'd13;
  localparam logic [7:0] SEP_SECOND_RESET = 8'd10;
  localparam logic [7:0] PAD_CHAR         = 8'h3d;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SEP_LENGTH = 2'd0,
    CFG_SEP_FIRST  = 2'd1,
    CFG_SEP_SECOND = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_DATA   = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    JOB_FULL = 2'd0,
    JOB_PAD1 = 2'd1,
    JOB_PAD2 = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [1:0]  sep_count;
    logic [23:0] group;
  } job_t;

  typedef struct packed {
    logic [1:0] sep_length;
    logic [7:0] sep_first;
    logic [7:0] sep_second;
  } cfg_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/b64lw_in_if.sv
// Interface: input channel carrying operation and data byte with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface b64lw_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: hdl/b64lw_out_if.sv
// Interface: result channel carrying one character and its last flag with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface b64lw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

FILE: hdl/b64lw_front.sv
// Front end: gathers bytes, tracks the line column and posts encode jobs to the queue.
`timescale 1ns / 1ps
`default_nettype none
module b64lw_front #(
  parameter int LINE_WIDTH = b64lw_pkg::LINE_WIDTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire b64lw_pkg::cfg_t cfg,
  b64lw_in_if.sink            in_ch,
  input  wire logic           job_full,
  output logic                job_push,
  output b64lw_pkg::job_t     job
);
  import b64lw_pkg::*;

  logic [15:0]      pend_r, pend_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] col_sum;
  logic             wrap;
  logic             accept;
  logic [1:0]       sep_len;

  assign in_ch.ready = !job_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign col_sum     = col_r + COL_W'(4);
  assign wrap        = col_sum >= COL_W'(LINE_WIDTH);
  assign sep_len     = (cfg.sep_length > 2'd2) ? 2'd2 : cfg.sep_length;

  always_comb begin
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    col_nxt        = col_r;
    job_push       = 1'b0;
    job.kind       = JOB_FULL;
    job.sep_count  = 2'd0;
    job.group      = {pend_r, in_ch.data_byte};
    if (accept) begin
      if (op_t'(in_ch.operation) == OP_DATA) begin
        if (cnt_r < 2'd2) begin
          pend_nxt = {pend_r[7:0], in_ch.data_byte};
          cnt_nxt  = cnt_r + 2'd1;
        end else begin
          job_push      = 1'b1;
          job.sep_count = wrap ? sep_len : 2'd0;
          pend_nxt      = 16'd0;
          cnt_nxt       = 2'd0;
          col_nxt       = wrap ? '0 : col_sum;
        end
      end else begin
        if (cnt_r == 2'd1) begin
          job_push  = 1'b1;
          job.kind  = JOB_PAD1;
          job.group = {pend_r[7:0], 16'd0};
          pend_nxt  = 16'd0;
          cnt_nxt   = 2'd0;
        end else if (cnt_r == 2'd2) begin
          job_push  = 1'b1;
          job.kind  = JOB_PAD2;
          job.group = {pend_r, 8'd0};
          pend_nxt  = 16'd0;
          cnt_nxt   = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 16'd0;
      cnt_r  <= 2'd0;
      col_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/b64lw_job_fifo.sv
// Job queue: small register FIFO between the front end and the character emitter.
`timescale 1ns / 1ps
`default_nettype none
module b64lw_job_fifo #(
  parameter int DEPTH = b64lw_pkg::JOB_FIFO_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire b64lw_pkg::job_t push_job,
  output logic                 full,
  input  wire logic            pop,
  output b64lw_pkg::job_t      head,
  output logic                 head_valid
);
  import b64lw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = cnt_r == CNT_W'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/b64lw_back.sv
// Back end: unless stalled, walks each job one character per cycle into the output register.
`timescale 1ns / 1ps
`default_nettype none
module b64lw_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire b64lw_pkg::cfg_t cfg,
  input  wire b64lw_pkg::job_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  b64lw_out_if.source          out_ch
);
  import b64lw_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic [5:0] sext;
  logic [7:0] ch;
  logic [2:0] n_chars;
  logic       is_last;
  logic       fire;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;

  assign n_chars = 3'd4 + {1'b0, head.sep_count};
  assign is_last = idx_r == (n_chars - 3'd1);
  assign fire    = head_valid && (!out_valid_r || out_ch.ready);
  assign pop     = fire && is_last;

  always_comb begin
    case (idx_r)
      3'd0:    sext = head.group[23:18];
      3'd1:    sext = head.group[17:12];
      3'd2:    sext = head.group[11:6];
      default: sext = head.group[5:0];
    endcase
  end

  always_comb begin
    case (idx_r)
      3'd0, 3'd1: ch = b64_char(sext);
      3'd2:       ch = (head.kind == JOB_PAD1) ? PAD_CHAR : b64_char(sext);
      3'd3:       ch = (head.kind == JOB_FULL) ? b64_char(sext) : PAD_CHAR;
      3'd4:       ch = cfg.sep_first;
      default:    ch = cfg.sep_second;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ch;
      out_last_nxt  = is_last;
      idx_nxt       = is_last ? 3'd0 : idx_r + 3'd1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire

FILE: hdl/base64_encoder_line_wrap.sv
// Top level: streaming Base64 encoder with line wrapping and configurable separator.
// A completed group or flush is queued as a job and emitted through the output register.
// Throughput: one input transaction per cycle while the job queue has room; the
// character emitter sends one char per cycle unless stalled, 4 to 6 per group or flush.
// Reset: synchronous, active low; clears pending bytes, line column, queue and emitter,
// and loads the separator registers with CR LF, length 2. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module base64_encoder_line_wrap #(
  parameter int LINE_WIDTH = b64lw_pkg::LINE_WIDTH_DEFAULT,
  parameter int FIFO_DEPTH = b64lw_pkg::JOB_FIFO_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [b64lw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [b64lw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  b64lw_in_if.sink                               in_ch,
  b64lw_out_if.source                            out_ch
);
  import b64lw_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t push_job, head;
  logic push, full, pop, head_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SEP_LENGTH: cfg_nxt.sep_length = cfg_wdata[1:0];
        CFG_SEP_FIRST:  cfg_nxt.sep_first  = cfg_wdata;
        CFG_SEP_SECOND: cfg_nxt.sep_second = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sep_length <= SEP_LENGTH_RESET;
      cfg_r.sep_first  <= SEP_FIRST_RESET;
      cfg_r.sep_second <= SEP_SECOND_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  b64lw_front #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .job_full (full),
    .job_push (push),
    .job      (push_job)
  );

  b64lw_job_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  b64lw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
